// ===== rtl/core/crps_pkg.sv =====
package crps_pkg;

  localparam int COORD_W = 32;
  localparam int LAYER_W = 4;
  localparam int INDEX_W = 22;
  localparam int STEP_W  = 5;
  localparam int T_W     = 17;
  localparam int DATA_W  = 128;
  localparam int PAD_W   = DATA_W - 3 * COORD_W - LAYER_W - INDEX_W;

  localparam logic [STEP_W-1:0] MAX_STEPS = 5'd16;

  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef struct packed {
    point_t         p0;
    point_t         p1;
    point_t         p2;
    point_t         p3;
    logic [T_W-1:0] t;
  } cr_ops_t;

  typedef struct packed {
    logic [T_W-1:0]    q;
    logic [STEP_W-1:0] r;
  } t_step_t;

  // quotient and remainder of 2^16 / s
  function automatic t_step_t t_step(input logic [STEP_W-1:0] s);
    t_step_t v;
    case (s)
      5'd1:    v = '{q: 17'd65536, r: 5'd0};
      5'd2:    v = '{q: 17'd32768, r: 5'd0};
      5'd3:    v = '{q: 17'd21845, r: 5'd1};
      5'd4:    v = '{q: 17'd16384, r: 5'd0};
      5'd5:    v = '{q: 17'd13107, r: 5'd1};
      5'd6:    v = '{q: 17'd10922, r: 5'd4};
      5'd7:    v = '{q: 17'd9362,  r: 5'd2};
      5'd8:    v = '{q: 17'd8192,  r: 5'd0};
      5'd9:    v = '{q: 17'd7281,  r: 5'd7};
      5'd10:   v = '{q: 17'd6553,  r: 5'd6};
      5'd11:   v = '{q: 17'd5957,  r: 5'd9};
      5'd12:   v = '{q: 17'd5461,  r: 5'd4};
      5'd13:   v = '{q: 17'd5041,  r: 5'd3};
      5'd14:   v = '{q: 17'd4681,  r: 5'd2};
      5'd15:   v = '{q: 17'd4369,  r: 5'd1};
      5'd16:   v = '{q: 17'd4096,  r: 5'd0};
      5'd17:   v = '{q: 17'd3855,  r: 5'd1};
      5'd18:   v = '{q: 17'd3640,  r: 5'd16};
      5'd19:   v = '{q: 17'd3449,  r: 5'd5};
      5'd20:   v = '{q: 17'd3276,  r: 5'd16};
      5'd21:   v = '{q: 17'd3120,  r: 5'd16};
      5'd22:   v = '{q: 17'd2978,  r: 5'd20};
      5'd23:   v = '{q: 17'd2849,  r: 5'd9};
      5'd24:   v = '{q: 17'd2730,  r: 5'd16};
      5'd25:   v = '{q: 17'd2621,  r: 5'd11};
      5'd26:   v = '{q: 17'd2520,  r: 5'd16};
      5'd27:   v = '{q: 17'd2427,  r: 5'd7};
      5'd28:   v = '{q: 17'd2340,  r: 5'd16};
      5'd29:   v = '{q: 17'd2259,  r: 5'd25};
      5'd30:   v = '{q: 17'd2184,  r: 5'd16};
      5'd31:   v = '{q: 17'd2114,  r: 5'd2};
      default: v = '{q: 17'd0,     r: 5'd0};
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/catmull_rom_path_smoother_core.sv =====
// A new waypoint is accepted only in IDLE, after the beats for the last one have been
// issued and the path history updated; output stalls hold it back further. Each
// interpolated point is three axes of seven passes through the one shared 37x18
// multiplier.
// Reset (rst, synchronous, active high) clears the step count and the path history.
module catmull_rom_path_smoother_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, pos_z, layer, node_index, zero pad
  input  logic [crps_pkg::DATA_W-1:0] s_axis_tdata,
  // is_refined
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_x, out_y, out_z, out_layer, out_node_index, zero pad
  output logic [crps_pkg::DATA_W-1:0] m_axis_tdata,
  // out_refined
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [crps_pkg::STEP_W-1:0] cfg_data
);

  typedef enum logic [2:0] {IDLE, DECIDE, EVAL, WAIT, SEG_EMIT, EMIT_CUR, UPDATE} state_t;

  state_t                         state;
  logic [crps_pkg::STEP_W-1:0]    smoothing_steps;
  logic [crps_pkg::STEP_W-1:0]    steps;
  logic [crps_pkg::STEP_W-1:0]    step_i;
  logic [crps_pkg::T_W-1:0]       t_val;
  logic [crps_pkg::STEP_W-1:0]    t_rem;
  logic                           seg;
  logic [1:0]                     seen;

  crps_pkg::point_t               cur_pt;
  logic [crps_pkg::LAYER_W-1:0]   cur_layer;
  logic [crps_pkg::INDEX_W-1:0]   cur_index;
  logic                           cur_ref;
  logic                           cur_last;

  crps_pkg::point_t               win [3];
  logic [crps_pkg::LAYER_W-1:0]   win_layer [3];
  logic [crps_pkg::INDEX_W-1:0]   win_index [3];

  crps_pkg::cr_ops_t              ops;
  crps_pkg::point_t               res;
  crps_pkg::t_step_t              ts;
  logic [crps_pkg::LAYER_W-1:0]   tag_layer;
  logic [crps_pkg::INDEX_W-1:0]   tag_index;
  logic                           start;
  logic                           done;
  logic                           slot_free;
  logic                           emit;
  logic [crps_pkg::STEP_W:0]      rem_sum;

  assign s_axis_tready = (state == IDLE);
  assign cfg_ready     = 1'b1;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign emit          = ((state == SEG_EMIT) || (state == EMIT_CUR)) && slot_free;
  assign start         = (state == EVAL);
  assign ts            = crps_pkg::t_step(steps);
  assign rem_sum       = {1'b0, t_rem} + {1'b0, ts.r};

  always_comb begin
    ops.t = t_val;
    if (!seg) begin
      ops.p0    = (seen == 2'd2) ? win[1] : win[0];
      ops.p1    = win[1];
      ops.p2    = win[2];
      ops.p3    = cur_pt;
      tag_layer = win_layer[1];
      tag_index = win_index[1];
    end else begin
      ops.p0    = win[1];
      ops.p1    = win[2];
      ops.p2    = cur_pt;
      ops.p3    = cur_pt;
      tag_layer = win_layer[2];
      tag_index = win_index[2];
    end
  end

  crps_eval_unit u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ops   (ops),
    .done  (done),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      smoothing_steps <= '0;
      seen            <= 2'd0;
      seg             <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        smoothing_steps <= cfg_data;
      end
      if (m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            cur_pt[0] <= s_axis_tdata[31:0];
            cur_pt[1] <= s_axis_tdata[63:32];
            cur_pt[2] <= s_axis_tdata[95:64];
            cur_layer <= s_axis_tdata[99:96];
            cur_index <= s_axis_tdata[121:100];
            cur_ref   <= s_axis_tuser;
            cur_last  <= s_axis_tlast;
            steps     <= (smoothing_steps > crps_pkg::MAX_STEPS) ?
                         crps_pkg::MAX_STEPS : smoothing_steps;
            state     <= DECIDE;
          end
        end
        DECIDE: begin
          if (seen == 2'd0 || steps == '0) begin
            state <= EMIT_CUR;
          end else if (seen == 2'd1) begin
            state <= cur_last ? EMIT_CUR : UPDATE;
          end else begin
            seg    <= 1'b0;
            step_i <= 5'd1;
            t_val  <= ts.q;
            t_rem  <= ts.r;
            state  <= EVAL;
          end
        end
        EVAL: state <= WAIT;
        WAIT: begin
          if (done) begin
            state <= SEG_EMIT;
          end
        end
        SEG_EMIT: begin
          if (slot_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{crps_pkg::PAD_W{1'b0}}, tag_index, tag_layer,
                              res[2], res[1], res[0]};
            m_axis_tuser  <= 1'b1;
            m_axis_tlast  <= 1'b0;
            if (step_i == steps) begin
              if (!seg && cur_last) begin
                seg    <= 1'b1;
                step_i <= 5'd1;
                t_val  <= ts.q;
                t_rem  <= ts.r;
                state  <= EVAL;
              end else if (!seg) begin
                state <= UPDATE;
              end else begin
                state <= EMIT_CUR;
              end
            end else begin
              step_i <= step_i + 5'd1;
              if (rem_sum >= {1'b0, steps}) begin
                t_val <= t_val + ts.q + 17'd1;
                t_rem <= 5'(rem_sum - {1'b0, steps});
              end else begin
                t_val <= t_val + ts.q;
                t_rem <= rem_sum[crps_pkg::STEP_W-1:0];
              end
              state <= EVAL;
            end
          end
        end
        EMIT_CUR: begin
          if (slot_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{crps_pkg::PAD_W{1'b0}}, cur_index, cur_layer,
                              cur_pt[2], cur_pt[1], cur_pt[0]};
            m_axis_tuser  <= cur_ref;
            m_axis_tlast  <= cur_last;
            state         <= UPDATE;
          end
        end
        UPDATE: begin
          if (cur_last) begin
            seen <= 2'd0;
          end else begin
            win[0]       <= win[1];
            win[1]       <= win[2];
            win[2]       <= cur_pt;
            win_layer[0] <= win_layer[1];
            win_layer[1] <= win_layer[2];
            win_layer[2] <= cur_layer;
            win_index[0] <= win_index[1];
            win_index[1] <= win_index[2];
            win_index[2] <= cur_index;
            seen         <= (seen == 2'd3) ? 2'd3 : seen + 2'd1;
          end
          seg   <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/crps_eval_unit.sv =====
module crps_eval_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  crps_pkg::cr_ops_t ops,
  output logic              done,
  output crps_pkg::point_t  res
);

  typedef enum logic [1:0] {IDLE, SETUP, MUL} state_t;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  state_t             state;
  logic [1:0]         axis;
  logic [2:0]         op;
  logic signed [36:0] coef_b, coef_c, coef_d;
  logic signed [39:0] acc;
  logic signed [54:0] prod;

  logic signed [31:0] a0, a1, a2, a3;
  logic signed [36:0] e0, e1, e2, e3;
  logic signed [36:0] b_s, c_s, d_s;
  logic signed [36:0] fl;
  logic signed [36:0] opnd;
  logic signed [17:0] tq;
  logic signed [54:0] prod_c;
  logic signed [39:0] acc_sum;
  logic signed [39:0] half;
  logic [31:0]        sat;

  assign a0 = $signed(ops.p0[axis]);
  assign a1 = $signed(ops.p1[axis]);
  assign a2 = $signed(ops.p2[axis]);
  assign a3 = $signed(ops.p3[axis]);
  assign e0 = 37'(a0);
  assign e1 = 37'(a1);
  assign e2 = 37'(a2);
  assign e3 = 37'(a3);

  assign b_s = e2 - e0;
  assign c_s = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign d_s = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;

  // floor of prod / 2^16; bounded by the operand since T <= 1.0
  assign fl = 37'(prod >>> 16);

  always_comb begin
    case (op)
      3'd0:    opnd = coef_b;
      3'd1:    opnd = coef_c;
      3'd3:    opnd = coef_d;
      default: opnd = fl;
    endcase
  end

  assign tq      = $signed({1'b0, ops.t});
  assign prod_c  = opnd * tq;
  assign acc_sum = acc + 40'(fl);
  assign half    = acc_sum >>> 1;

  always_comb begin
    if (half > SAT_MAX) begin
      sat = SAT_MAX[31:0];
    end else if (half < SAT_MIN) begin
      sat = SAT_MIN[31:0];
    end else begin
      sat = half[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      axis  <= 2'd0;
      op    <= 3'd0;
    end else begin
      done <= (state == MUL) && (op == 3'd6) && (axis == 2'd2);
      case (state)
        IDLE: begin
          if (start) begin
            axis  <= 2'd0;
            state <= SETUP;
          end
        end
        SETUP: begin
          coef_b <= b_s;
          coef_c <= c_s;
          coef_d <= d_s;
          acc    <= 40'(e1) <<< 1;
          op     <= 3'd0;
          state  <= MUL;
        end
        MUL: begin
          prod <= prod_c;
          if (op == 3'd1 || op == 3'd3) begin
            acc <= acc_sum;
          end
          op <= op + 3'd1;
          if (op == 3'd6) begin
            res[axis] <= sat;
            if (axis == 2'd2) begin
              state <= IDLE;
            end else begin
              axis  <= axis + 2'd1;
              state <= SETUP;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_catmull_rom_path_smoother_core.sv =====
module tb_catmull_rom_path_smoother_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     IDLE_WAIT   = 16;
  localparam int     STALL_LIMIT = 20000;
  localparam int     LONG_HOLD   = 400;
  localparam int     RAND_ITEMS  = 350;
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;

  typedef struct packed {
    logic [crps_pkg::COORD_W-1:0] x;
    logic [crps_pkg::COORD_W-1:0] y;
    logic [crps_pkg::COORD_W-1:0] z;
    logic [crps_pkg::LAYER_W-1:0] layer;
    logic [crps_pkg::INDEX_W-1:0] node;
    logic                         refined;
    logic                         last;
  } waypoint_t;

  typedef enum logic [1:0] {BEAT_POINT, BEAT_CFG, BEAT_DRAIN} beat_kind_t;

  typedef struct {
    beat_kind_t                  kind;
    waypoint_t                   pt;
    logic [crps_pkg::STEP_W-1:0] steps;
  } stim_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [crps_pkg::DATA_W-1:0]   s_axis_tdata  = '0;
  logic                          s_axis_tuser  = 1'b0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [crps_pkg::DATA_W-1:0]   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [crps_pkg::STEP_W-1:0]   cfg_data  = '0;

  catmull_rom_path_smoother_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  stim_beat_t pending_beats[$];
  waypoint_t  expected_pts[$];
  logic       results_pending = 1'b0;
  int         error_cnt = 0;

  // ---------------- predictor ----------------
  logic [crps_pkg::STEP_W-1:0] step_reg;
  waypoint_t                   hist [3];
  int                          seen;

  function automatic logic [crps_pkg::COORD_W-1:0] spline_axis(longint p0, longint p1,
                                                               longint p2, longint p3,
                                                               longint t);
    longint a, b, c, d, tb, tc, td, r;
    a  = 2 * p1;
    b  = p2 - p0;
    c  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d  = -p0 + 3 * p1 - 3 * p2 + p3;
    tb = (b * t) >>> 16;
    tc = (((c * t) >>> 16) * t) >>> 16;
    td = (((((d * t) >>> 16) * t) >>> 16) * t) >>> 16;
    r  = (a + tb + tc + td) >>> 1;
    if (r > COORD_MAX) r = COORD_MAX;
    else if (r < COORD_MIN) r = COORD_MIN;
    return r[crps_pkg::COORD_W-1:0];
  endfunction

  // tags come from the segment start, q1
  function automatic void push_segment(int steps, waypoint_t q0, waypoint_t q1,
                                       waypoint_t q2, waypoint_t q3);
    waypoint_t o;
    longint    t;
    for (int i = 1; i <= steps; i++) begin
      t = (longint'(i) << 16) / steps;
      o.x       = spline_axis($signed(q0.x), $signed(q1.x), $signed(q2.x), $signed(q3.x), t);
      o.y       = spline_axis($signed(q0.y), $signed(q1.y), $signed(q2.y), $signed(q3.y), t);
      o.z       = spline_axis($signed(q0.z), $signed(q1.z), $signed(q2.z), $signed(q3.z), t);
      o.layer   = q1.layer;
      o.node    = q1.node;
      o.refined = 1'b1;
      o.last    = 1'b0;
      expected_pts.push_back(o);
    end
  endfunction

  function automatic void smooth_waypoint(waypoint_t w);
    int        steps;
    waypoint_t fin;
    steps = (step_reg > crps_pkg::MAX_STEPS) ? int'(crps_pkg::MAX_STEPS) : int'(step_reg);
    fin = w;
    fin.last = 1'b1;
    if (seen == 0 || steps == 0) begin
      expected_pts.push_back(w);
    end else if (seen == 1) begin
      if (w.last) expected_pts.push_back(fin);
    end else begin
      if (seen == 2) push_segment(steps, hist[1], hist[1], hist[2], w);
      else push_segment(steps, hist[0], hist[1], hist[2], w);
      if (w.last) begin
        push_segment(steps, hist[1], hist[2], w, w);
        expected_pts.push_back(fin);
      end
    end
    if (w.last) begin
      hist[0] = '0;
      hist[1] = '0;
      hist[2] = '0;
      seen = 0;
    end else begin
      hist[0] = hist[1];
      hist[1] = hist[2];
      hist[2] = w;
      if (seen < 3) seen++;
    end
  endfunction

  // ---------------- input capture, prediction, output check ----------------
  waypoint_t in_pt, got_pt, want_pt;

  always @(posedge clk) begin
    if (rst) begin
      step_reg = '0;
      hist[0] = '0;
      hist[1] = '0;
      hist[2] = '0;
      seen = 0;
      results_pending <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) step_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        in_pt.x       = s_axis_tdata[31:0];
        in_pt.y       = s_axis_tdata[63:32];
        in_pt.z       = s_axis_tdata[95:64];
        in_pt.layer   = s_axis_tdata[99:96];
        in_pt.node    = s_axis_tdata[121:100];
        in_pt.refined = s_axis_tuser;
        in_pt.last    = s_axis_tlast;
        smooth_waypoint(in_pt);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_pt.x       = m_axis_tdata[31:0];
        got_pt.y       = m_axis_tdata[63:32];
        got_pt.z       = m_axis_tdata[95:64];
        got_pt.layer   = m_axis_tdata[99:96];
        got_pt.node    = m_axis_tdata[121:100];
        got_pt.refined = m_axis_tuser;
        got_pt.last    = m_axis_tlast;
        if (expected_pts.size() == 0) begin
          if (error_cnt < 10)
            $display("unexpected output beat: x=%h y=%h z=%h layer=%0d node=%0d ref=%b last=%b",
                     got_pt.x, got_pt.y, got_pt.z, got_pt.layer, got_pt.node,
                     got_pt.refined, got_pt.last);
          error_cnt++;
        end else begin
          want_pt = expected_pts.pop_front();
          if (got_pt.x !== want_pt.x || got_pt.y !== want_pt.y || got_pt.z !== want_pt.z ||
              got_pt.layer !== want_pt.layer || got_pt.node !== want_pt.node ||
              got_pt.refined !== want_pt.refined || got_pt.last !== want_pt.last) begin
            if (error_cnt < 10) begin
              $display("mismatch exp: x=%h y=%h z=%h layer=%0d node=%0d ref=%b last=%b",
                       want_pt.x, want_pt.y, want_pt.z, want_pt.layer, want_pt.node,
                       want_pt.refined, want_pt.last);
              $display("         got: x=%h y=%h z=%h layer=%0d node=%0d ref=%b last=%b",
                       got_pt.x, got_pt.y, got_pt.z, got_pt.layer, got_pt.node,
                       got_pt.refined, got_pt.last);
            end
            error_cnt++;
          end
        end
      end
      results_pending <= (expected_pts.size() != 0);
    end
  end

  // ---------------- driver ----------------
  int         quiet_cnt = 0;
  int         burst_left = 8;
  int         gap_left = 0;
  logic       next_valid, next_cfg;
  stim_beat_t head_beat;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid     <= 1'b0;
      quiet_cnt = 0;
    end else begin
      if (results_pending || s_axis_tvalid) quiet_cnt = 0;
      else if (quiet_cnt < 1000) quiet_cnt++;
      if (!(s_axis_tvalid && !s_axis_tready) && !(cfg_valid && !cfg_ready)) begin
        next_valid = 1'b0;
        next_cfg   = 1'b0;
        if (pending_beats.size() != 0) begin
          head_beat = pending_beats[0];
          if (head_beat.kind == BEAT_POINT) begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              next_valid = 1'b1;
              s_axis_tdata <= {{crps_pkg::PAD_W{1'b0}}, head_beat.pt.node, head_beat.pt.layer,
                               head_beat.pt.z, head_beat.pt.y, head_beat.pt.x};
              s_axis_tuser <= head_beat.pt.refined;
              s_axis_tlast <= head_beat.pt.last;
              void'(pending_beats.pop_front());
              if (burst_left <= 1) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                          : $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
              end else begin
                burst_left--;
              end
            end
          end else if (quiet_cnt >= IDLE_WAIT && !cfg_valid) begin
            if (head_beat.kind == BEAT_CFG) begin
              next_cfg = 1'b1;
              cfg_data <= head_beat.steps;
            end
            void'(pending_beats.pop_front());
          end
        end
        s_axis_tvalid <= next_valid;
        cfg_valid     <= next_cfg;
      end
    end
  end

  // ---------------- receiver ----------------
  int   rx_cycle = 0;
  int   hold_left = 0;
  int   holds_done = 0;
  int   next_hold_at = 1500;
  int   rx_mode = 0;
  int   mode_left = 0;
  logic rdy;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_done < 2 && rx_cycle >= next_hold_at && s_axis_tvalid &&
                   results_pending) begin
        hold_left = LONG_HOLD;
        holds_done++;
        next_hold_at = rx_cycle + 40000;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ($urandom_range(0, 9) < 3);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // ---------------- watchdog ----------------
  int stall_cnt = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic waypoint_t mk_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [3:0] layer, logic [21:0] node,
                                      logic refined, logic last);
    waypoint_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    w.layer = layer;
    w.node = node;
    w.refined = refined;
    w.last = last;
    return w;
  endfunction

  function automatic void add_point(waypoint_t w);
    stim_beat_t b;
    b.kind  = BEAT_POINT;
    b.pt    = w;
    b.steps = '0;
    pending_beats.push_back(b);
  endfunction

  function automatic void add_cfg(logic [crps_pkg::STEP_W-1:0] steps);
    stim_beat_t b;
    b.kind  = BEAT_CFG;
    b.pt    = '0;
    b.steps = steps;
    pending_beats.push_back(b);
  endfunction

  function automatic void add_drain();
    stim_beat_t b;
    b.kind  = BEAT_DRAIN;
    b.pt    = '0;
    b.steps = '0;
    pending_beats.push_back(b);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h1fffff) - 32'h100000;
    endcase
  endfunction

  function automatic void add_path(int len, bit wild);
    logic [31:0] c [3];
    logic [31:0] d;
    int          span;
    span = $urandom_range(4, 20);
    for (int k = 0; k < 3; k++) c[k] = rand_coord();
    for (int i = 0; i < len; i++) begin
      if (i != 0) begin
        for (int k = 0; k < 3; k++) begin
          if (wild) begin
            c[k] = rand_coord();
          end else begin
            d = $urandom & ((32'd1 << span) - 1);
            c[k] = c[k] + d - (32'd1 << (span - 1));
          end
        end
      end
      add_point(mk_pt(c[0], c[1], c[2], 4'($urandom_range(0, 15)),
                      22'($urandom_range(0, 22'h3fffff)),
                      1'($urandom_range(0, 1)), (i == len - 1)));
    end
  endfunction

  int rand_items;
  int sel, len, npaths;
  logic [crps_pkg::STEP_W-1:0] steps_pick;

  initial begin
    // reset step count is zero: pass-through with field extremes
    add_point(mk_pt(32'h7fffffff, 32'h80000000, 32'h0, 4'hf, 22'h3fffff, 1'b1, 1'b0));
    add_point(mk_pt(32'h80000000, 32'h7fffffff, 32'hffffffff, 4'h0, 22'h0, 1'b0, 1'b1));
    add_cfg(5'd1);
    add_point(mk_pt(32'd100, 32'd200, 32'd300, 4'd3, 22'd5, 1'b0, 1'b1));
    add_point(mk_pt(32'd1000, -32'sd1000, 32'd0, 4'd1, 22'd10, 1'b1, 1'b0));
    add_point(mk_pt(32'd2000, -32'sd3000, 32'd500, 4'd2, 22'd11, 1'b0, 1'b1));
    add_point(mk_pt(32'd0, 32'd0, 32'd0, 4'd4, 22'd1, 1'b0, 1'b0));
    add_point(mk_pt(32'd256, 32'd512, -32'sd256, 4'd5, 22'd2, 1'b1, 1'b0));
    add_point(mk_pt(32'd1024, 32'd0, 32'd768, 4'd6, 22'd3, 1'b0, 1'b1));
    // full steps with rail-to-rail swings to force saturation
    add_cfg(5'd16);
    add_point(mk_pt(32'h7fffffff, 32'h80000000, 32'h7fffffff, 4'd7, 22'd100, 1'b0, 1'b0));
    add_point(mk_pt(32'h80000000, 32'h7fffffff, 32'h80000000, 4'd8, 22'd101, 1'b1, 1'b0));
    add_point(mk_pt(32'h7fffffff, 32'h80000000, 32'h7fffffff, 4'd9, 22'd102, 1'b0, 1'b0));
    add_point(mk_pt(32'h80000000, 32'h7fffffff, 32'h80000000, 4'd10, 22'd103, 1'b1, 1'b1));
    // above max: clamps to max
    add_cfg(5'd31);
    add_path(3, 1'b0);
    // step count changed mid-path
    add_cfg(5'd2);
    add_point(mk_pt(32'd0, 32'd0, 32'd0, 4'd1, 22'd7, 1'b0, 1'b0));
    add_point(mk_pt(32'd2560, -32'sd2560, 32'd1280, 4'd2, 22'd8, 1'b0, 1'b0));
    add_cfg(5'd0);
    add_point(mk_pt(32'd5120, 32'd0, 32'd2560, 4'd3, 22'd9, 1'b1, 1'b0));
    add_cfg(5'd3);
    add_point(mk_pt(32'd7680, 32'd2560, -32'sd1280, 4'd4, 22'd10, 1'b0, 1'b0));
    add_point(mk_pt(32'd10240, 32'd5120, 32'd0, 4'd5, 22'd11, 1'b1, 1'b1));

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) steps_pick = 5'd0;
      else if (sel < 13) steps_pick = 5'($urandom_range(1, 4));
      else if (sel < 17) steps_pick = 5'($urandom_range(5, 12));
      else if (sel < 19) steps_pick = 5'($urandom_range(13, 16));
      else steps_pick = 5'($urandom_range(17, 31));
      add_cfg(steps_pick);
      npaths = $urandom_range(1, 4);
      repeat (npaths) begin
        sel = $urandom_range(0, 9);
        len = (sel == 0) ? 1 : (sel == 1) ? 2 : $urandom_range(3, 10);
        add_path(len, ($urandom_range(0, 3) == 0));
        rand_items += len;
      end
      if ($urandom_range(0, 3) == 0) add_drain();
    end
    add_cfg(5'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_beats.size() != 0 || s_axis_tvalid || cfg_valid ||
           expected_pts.size() != 0)
      @(negedge clk);
    repeat (64) @(negedge clk);
    if (expected_pts.size() != 0)
      $display("%0d expected beats never arrived", expected_pts.size());
    if (error_cnt == 0 && expected_pts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== catmull_rom_path_smoother_core.f =====
rtl/core/crps_pkg.sv
rtl/core/crps_eval_unit.sv
rtl/core/catmull_rom_path_smoother_core.sv
tb/sv/tb_catmull_rom_path_smoother_core.sv
